// ----- rtl/periodic_task_timer_table_assert.svh -----
// Assertion macros for the timer table RTL, included by ptt_ctrl.
// Uses the module's clock and reset signals by name; no other dependencies.
`ifndef PERIODIC_TASK_TIMER_TABLE_ASSERT_SVH
`define PERIODIC_TASK_TIMER_TABLE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PTT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define PTT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/ptt_pkg.sv -----
// Package for the periodic task timer table: sizes, operation and status
// codes, and the command/status structs between controller and datapath.
`timescale 1ns / 1ps

package ptt_pkg;

   localparam int TASK_SLOTS = 16;
   localparam int TIME_BITS  = 32;
   localparam int IDX_BITS   = $clog2(TASK_SLOTS);

   localparam int FUNC_W     = 3;
   localparam int IN_TIME_W  = 32;
   localparam int SLOT_W     = 4;
   localparam int COUNT_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = ((IN_TIME_W + SLOT_W + IN_TIME_W + COUNT_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((STATUS_W + SLOT_W + 2 + 7) / 8) * 8;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_TICK,
      FUNC_ADD,
      FUNC_ENABLE,
      FUNC_DISABLE,
      FUNC_START,
      FUNC_STOP,
      FUNC_CLEAR
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK,
      STAT_FULL,
      STAT_NO_TASK,
      STAT_NONE
   } status_type;

   typedef struct packed {
      logic latch_req;
      logic exec_simple;
      logic scan_clear;
      logic scan_step;
      logic decide;
      logic update;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      func_type func;
      logic     running;
      logic     scan_last;
      logic     found_best;
   } ctrl_sts_type;

endpackage

// ----- rtl/periodic_task_timer_table.sv -----
// Periodic task timer table: 16 slots, earliest-due dispatch on tick.
// Add, enable, disable, stop, clear, unused codes and a tick while stopped go from accept
// through an execute step to the result; start and a running tick scan every slot, then drain,
// decide and, for a dispatching tick, update. The due-time scan reads one slot a cycle.
// One request at a time; the next can be taken in the same cycle the result turns valid, even
// while it waits. Synchronous active-high reset frees all slots and stops the table.
`timescale 1ns / 1ps

module periodic_task_timer_table
   import ptt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // now_time[31:0], task_slot[35:32], task_period[67:36], repeat_count[99:68], zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // func[2:0]
   input  logic [FUNC_W-1:0]     req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // status[1:0], slot_out[5:2], dispatched[6], retired[7]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   ptt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ptt_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata)
   );

endmodule

// ----- rtl/ptt_ram.sv -----
// Generic 1R1W RAM with registered read data.
// Self-contained; used for the per-slot due time, period and run count.
`timescale 1ns / 1ps

module ptt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/ptt_dpath.sv -----
// Datapath of the timer table: request latch, slot flags, task memories,
// scan pipeline, earliest-due tracking and result registers. Uses ptt_pkg, ptt_ram.
`timescale 1ns / 1ps

module ptt_dpath
   import ptt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  ctrl_cmd_type          cmd,
   output ctrl_sts_type          sts,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [FUNC_W-1:0]     req_tuser,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   // request latch
   func_type               func_ff,   func_in;
   logic [TIME_BITS-1:0]   now_ff,    now_in;
   logic [SLOT_W-1:0]      slot_ff,   slot_in;
   logic [TIME_BITS-1:0]   period_ff, period_in;
   logic [COUNT_W-1:0]     count_ff,  count_in;

   // slot flags and run state
   logic [TASK_SLOTS-1:0]  valid_ff,   valid_in;
   logic [TASK_SLOTS-1:0]  enabled_ff, enabled_in;
   logic                   running_ff, running_in;

   // scan
   logic [IDX_BITS-1:0]    ctr_ff,      ctr_in;
   logic                   pipe_vld_ff, pipe_vld_in;
   logic [IDX_BITS-1:0]    pipe_idx_ff, pipe_idx_in;
   logic                   any_ff,      any_in;
   logic                   found_ff,    found_in;
   logic [IDX_BITS-1:0]    best_idx_ff, best_idx_in;
   logic [TIME_BITS-1:0]   best_due_ff, best_due_in;

   // pending and output result
   status_type             res_status_ff, res_status_in;
   logic [SLOT_W-1:0]      res_slot_ff,   res_slot_in;
   logic                   res_disp_ff,   res_disp_in;
   logic                   res_ret_ff,    res_ret_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]      rsp_slot_ff,   rsp_slot_in;
   logic                   rsp_disp_ff,   rsp_disp_in;
   logic                   rsp_ret_ff,    rsp_ret_in;

   // memories
   logic                   due_we;
   logic [IDX_BITS-1:0]    due_wa;
   logic [TIME_BITS-1:0]   due_wd;
   logic [TIME_BITS-1:0]   due_rd;
   logic                   per_we;
   logic [IDX_BITS-1:0]    per_ra;
   logic [TIME_BITS-1:0]   per_rd;
   logic                   runs_we;
   logic [IDX_BITS-1:0]    runs_wa;
   logic [COUNT_W-1:0]     runs_wd;
   logic [COUNT_W-1:0]     runs_rd;

   logic                   free_found;
   logic [IDX_BITS-1:0]    free_idx;
   logic [IDX_BITS-1:0]    slot_idx;
   logic                   slot_ok;
   logic                   act;
   logic                   tick_cand;

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_BITS'(i);
         end
      end
   end

   assign slot_idx  = IDX_BITS'(slot_ff);
   assign slot_ok   = (32'(slot_ff) < TASK_SLOTS) && valid_ff[slot_idx];
   assign act       = pipe_vld_ff && valid_ff[pipe_idx_ff] && enabled_ff[pipe_idx_ff];
   assign tick_cand = act && (due_rd <= now_ff) && (!found_ff || (due_rd < best_due_ff));
   assign per_ra    = cmd.decide ? best_idx_ff : ctr_ff;

   always_comb begin
      func_in       = func_ff;
      now_in        = now_ff;
      slot_in       = slot_ff;
      period_in     = period_ff;
      count_in      = count_ff;
      valid_in      = valid_ff;
      enabled_in    = enabled_ff;
      running_in    = running_ff;
      ctr_in        = ctr_ff;
      pipe_vld_in   = cmd.scan_step;
      pipe_idx_in   = ctr_ff;
      any_in        = any_ff;
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      best_due_in   = best_due_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_disp_in   = res_disp_ff;
      res_ret_in    = res_ret_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_disp_in   = rsp_disp_ff;
      rsp_ret_in    = rsp_ret_ff;
      due_we        = 1'b0;
      due_wa        = ctr_ff;
      due_wd        = now_ff;
      per_we        = 1'b0;
      runs_we       = 1'b0;
      runs_wa       = best_idx_ff;
      runs_wd       = count_ff;

      if (cmd.latch_req) begin
         func_in   = func_type'(req_tuser);
         now_in    = TIME_BITS'(req_tdata[IN_TIME_W-1:0]);
         slot_in   = req_tdata[IN_TIME_W +: SLOT_W];
         period_in = TIME_BITS'(req_tdata[IN_TIME_W+SLOT_W +: IN_TIME_W]);
         count_in  = req_tdata[2*IN_TIME_W+SLOT_W +: COUNT_W];
      end

      if (cmd.scan_clear) begin
         ctr_in   = '0;
         any_in   = 1'b0;
         found_in = 1'b0;
      end
      if (cmd.scan_step) begin
         ctr_in = ctr_ff + 1'b1;
      end

      if (pipe_vld_ff && func_ff == FUNC_TICK) begin
         if (act) begin
            any_in = 1'b1;
         end
         if (tick_cand) begin
            found_in    = 1'b1;
            best_idx_in = pipe_idx_ff;
            best_due_in = due_rd;
         end
      end

      if (pipe_vld_ff && func_ff == FUNC_START && valid_ff[pipe_idx_ff]) begin
         due_we = 1'b1;
         due_wa = pipe_idx_ff;
         due_wd = now_ff + per_rd;
      end

      if (cmd.exec_simple) begin
         res_status_in = STAT_OK;
         res_slot_in   = '0;
         res_disp_in   = 1'b0;
         res_ret_in    = 1'b0;
         case (func_ff)
            FUNC_TICK: begin
               res_status_in = STAT_NONE;
            end
            FUNC_ADD: begin
               if (free_found) begin
                  valid_in[free_idx]   = 1'b1;
                  enabled_in[free_idx] = 1'b1;
                  due_we               = 1'b1;
                  due_wa               = free_idx;
                  due_wd               = now_ff;
                  per_we               = 1'b1;
                  runs_we              = 1'b1;
                  runs_wa              = free_idx;
                  runs_wd              = count_ff;
                  res_slot_in          = SLOT_W'(free_idx);
               end else begin
                  res_status_in = STAT_FULL;
               end
            end
            FUNC_ENABLE, FUNC_DISABLE: begin
               if (slot_ok) begin
                  enabled_in[slot_idx] = (func_ff == FUNC_ENABLE);
                  due_we               = 1'b1;
                  due_wa               = slot_idx;
                  due_wd               = (func_ff == FUNC_ENABLE) ? now_ff : '1;
               end else begin
                  res_status_in = STAT_NO_TASK;
               end
            end
            FUNC_STOP: begin
               running_in = 1'b0;
            end
            FUNC_CLEAR: begin
               valid_in   = '0;
               enabled_in = '0;
               running_in = 1'b0;
            end
            default: begin
            end
         endcase
      end

      if (cmd.decide) begin
         res_status_in = STAT_NONE;
         res_slot_in   = '0;
         res_disp_in   = 1'b0;
         res_ret_in    = 1'b0;
         if (func_ff == FUNC_START) begin
            running_in    = 1'b1;
            res_status_in = STAT_OK;
         end else if (!any_ff) begin
            running_in = 1'b0;
         end
      end

      if (cmd.update) begin
         res_status_in = STAT_OK;
         res_slot_in   = SLOT_W'(best_idx_ff);
         res_disp_in   = 1'b1;
         if (runs_rd == COUNT_W'(1)) begin
            valid_in[best_idx_ff]   = 1'b0;
            enabled_in[best_idx_ff] = 1'b0;
            res_ret_in              = 1'b1;
         end else begin
            res_ret_in = 1'b0;
            due_we     = 1'b1;
            due_wa     = best_idx_ff;
            due_wd     = best_due_ff + per_rd;
            runs_we    = (runs_rd != '0);
            runs_wa    = best_idx_ff;
            runs_wd    = runs_rd - 1'b1;
         end
      end

      if (cmd.load_rsp) begin
         rsp_status_in = res_status_ff;
         rsp_slot_in   = res_slot_ff;
         rsp_disp_in   = res_disp_ff;
         rsp_ret_in    = res_ret_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         enabled_ff  <= '0;
         running_ff  <= 1'b0;
         pipe_vld_ff <= 1'b0;
         any_ff      <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         enabled_ff  <= enabled_in;
         running_ff  <= running_in;
         pipe_vld_ff <= pipe_vld_in;
         any_ff      <= any_in;
         found_ff    <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      now_ff        <= now_in;
      slot_ff       <= slot_in;
      period_ff     <= period_in;
      count_ff      <= count_in;
      ctr_ff        <= ctr_in;
      pipe_idx_ff   <= pipe_idx_in;
      best_idx_ff   <= best_idx_in;
      best_due_ff   <= best_due_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_disp_ff   <= res_disp_in;
      res_ret_ff    <= res_ret_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_disp_ff   <= rsp_disp_in;
      rsp_ret_ff    <= rsp_ret_in;
   end

   ptt_ram #(.WIDTH(TIME_BITS), .DEPTH(TASK_SLOTS)) u_due_ram (
      .clock   (clock),
      .wr_en   (due_we),
      .wr_addr (due_wa),
      .wr_data (due_wd),
      .rd_addr (ctr_ff),
      .rd_data (due_rd)
   );

   ptt_ram #(.WIDTH(TIME_BITS), .DEPTH(TASK_SLOTS)) u_period_ram (
      .clock   (clock),
      .wr_en   (per_we),
      .wr_addr (free_idx),
      .wr_data (period_ff),
      .rd_addr (per_ra),
      .rd_data (per_rd)
   );

   ptt_ram #(.WIDTH(COUNT_W), .DEPTH(TASK_SLOTS)) u_runs_ram (
      .clock   (clock),
      .wr_en   (runs_we),
      .wr_addr (runs_wa),
      .wr_data (runs_wd),
      .rd_addr (best_idx_ff),
      .rd_data (runs_rd)
   );

   assign sts.func       = func_ff;
   assign sts.running    = running_ff;
   assign sts.scan_last  = (ctr_ff == IDX_BITS'(TASK_SLOTS - 1));
   assign sts.found_best = found_ff;

   assign rsp_tdata = RSP_DATA_W'({rsp_ret_ff, rsp_disp_ff, rsp_slot_ff, rsp_status_ff});

endmodule

// ----- rtl/ptt_ctrl.sv -----
// Controller of the timer table: request handshake, operation sequencing
// and result valid. Uses ptt_pkg and periodic_task_timer_table_assert.svh.
`timescale 1ns / 1ps
`include "periodic_task_timer_table_assert.svh"

module ptt_ctrl
   import ptt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  ctrl_sts_type sts,
   output ctrl_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_DRAIN,
      S_DECIDE,
      S_UPDATE,
      S_RESULT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      req_tready = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_EXEC;
            end
         end
         S_EXEC: begin
            if ((sts.func == FUNC_TICK && sts.running) || sts.func == FUNC_START) begin
               cmd.scan_clear = 1'b1;
               state_in       = S_SCAN;
            end else begin
               cmd.exec_simple = 1'b1;
               state_in        = S_RESULT;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            if (sts.func == FUNC_TICK && sts.found_best) begin
               state_in = S_UPDATE;
            end else begin
               state_in = S_RESULT;
            end
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = S_RESULT;
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = cmd.load_rsp | (rsp_valid_ff & ~rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   `PTT_ASSERT_NOW(a_no_overwrite, cmd.load_rsp, !rsp_valid_ff || rsp_tready, "result overwritten")
   `PTT_ASSERT_NEXT(a_scan_ends, state_ff == S_SCAN && sts.scan_last, state_ff == S_DRAIN, "scan overrun")
   `PTT_ASSERT_NOW(a_update_found, state_ff == S_UPDATE, $past(sts.found_best) && $past(state_ff == S_DECIDE), "update without due task")
   `PTT_ASSERT_NEXT(a_one_request, req_tvalid && req_tready, !req_tready, "second request taken while busy")

endmodule

// ----- tb/timer_table_checker.sv -----
`timescale 1ns / 1ps
// Response checker for the periodic task timer table: keeps its own copy of the task table,
// predicts the response to each accepted request and compares it field by field.
// Depends on ptt_pkg for widths and the operation and status codes.

module timer_table_checker
   import ptt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   // now_time[31:0], task_slot[35:32], task_period[67:36], repeat_count[99:68], zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // func[2:0]
   input  logic [FUNC_W-1:0]     req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // status[1:0], slot_out[5:2], dispatched[6], retired[7]
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   output int                    errors,
   output int                    pending,
   output int                    dispatches,
   output int                    retirements,
   output int                    full_hits
);

   localparam int SLOT_LSB   = IN_TIME_W;
   localparam int PERIOD_LSB = SLOT_LSB + SLOT_W;
   localparam int COUNT_LSB  = PERIOD_LSB + IN_TIME_W;

   typedef struct packed {
      logic              retired;
      logic              dispatched;
      logic [SLOT_W-1:0] slot;
      status_type        status;
   } outcome_t;

   logic [TIME_BITS-1:0] due_at    [TASK_SLOTS];
   logic [TIME_BITS-1:0] period_of [TASK_SLOTS];
   logic [COUNT_W-1:0]   runs_left [TASK_SLOTS];
   logic                 live      [TASK_SLOTS];
   logic                 armed     [TASK_SLOTS];
   logic                 running;
   outcome_t             outcome_q [$];

   initial begin
      errors      = 0;
      pending     = 0;
      dispatches  = 0;
      retirements = 0;
      full_hits   = 0;
   end

   // updates the table copy and returns the response the request should produce
   function automatic outcome_t apply_request(input logic [FUNC_W-1:0]    f,
                                              input logic [TIME_BITS-1:0] now,
                                              input logic [SLOT_W-1:0]    slot,
                                              input logic [TIME_BITS-1:0] per,
                                              input logic [COUNT_W-1:0]   cnt);
      outcome_t o;
      int       pick;
      bit       any_armed;
      o         = '0;
      pick      = -1;
      any_armed = 1'b0;
      case (f)
         FUNC_TICK: begin
            if (!running) begin
               o.status = STAT_NONE;
            end else begin
               for (int i = 0; i < TASK_SLOTS; i++) begin
                  if (live[i] && armed[i]) begin
                     any_armed = 1'b1;
                     if (due_at[i] <= now && (pick < 0 || due_at[i] < due_at[pick]))
                        pick = i;
                  end
               end
               if (!any_armed) begin
                  running  = 1'b0;
                  o.status = STAT_NONE;
               end else if (pick < 0) begin
                  o.status = STAT_NONE;
               end else begin
                  o.slot       = SLOT_W'(pick);
                  o.dispatched = 1'b1;
                  if (runs_left[pick] == 1) begin
                     live[pick]  = 1'b0;
                     armed[pick] = 1'b0;
                     o.retired   = 1'b1;
                  end else begin
                     if (runs_left[pick] != 0)
                        runs_left[pick] = runs_left[pick] - 1'b1;
                     due_at[pick] = due_at[pick] + period_of[pick];
                  end
               end
            end
         end
         FUNC_ADD: begin
            for (int i = TASK_SLOTS - 1; i >= 0; i--)
               if (!live[i])
                  pick = i;
            if (pick < 0) begin
               o.status = STAT_FULL;
            end else begin
               live[pick]      = 1'b1;
               armed[pick]     = 1'b1;
               due_at[pick]    = now;
               period_of[pick] = per;
               runs_left[pick] = cnt;
               o.slot          = SLOT_W'(pick);
            end
         end
         FUNC_ENABLE, FUNC_DISABLE: begin
            if (!live[slot]) begin
               o.status = STAT_NO_TASK;
            end else if (f == FUNC_ENABLE) begin
               armed[slot]  = 1'b1;
               due_at[slot] = now;
            end else begin
               armed[slot]  = 1'b0;
               due_at[slot] = '1;
            end
         end
         FUNC_START: begin
            for (int i = 0; i < TASK_SLOTS; i++)
               if (live[i])
                  due_at[i] = now + period_of[i];
            running = 1'b1;
         end
         FUNC_STOP: running = 1'b0;
         FUNC_CLEAR: begin
            for (int i = 0; i < TASK_SLOTS; i++) begin
               live[i]  = 1'b0;
               armed[i] = 1'b0;
            end
            running = 1'b0;
         end
         default: ;
      endcase
      return o;
   endfunction

   task automatic check_field(input string what, input int want, input int got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      outcome_t got;
      outcome_t want;
      if (reset) begin
         for (int i = 0; i < TASK_SLOTS; i++) begin
            live[i]  = 1'b0;
            armed[i] = 1'b0;
         end
         running = 1'b0;
         outcome_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = outcome_t'(rsp_tdata);
            if (outcome_q.size() == 0) begin
               errors++;
               $display("%0t: response with none expected, actual %h", $time, rsp_tdata);
            end else begin
               want = outcome_q.pop_front();
               check_field("status", int'(want.status), int'(got.status));
               check_field("slot_out", int'(want.slot), int'(got.slot));
               check_field("dispatched", int'(want.dispatched), int'(got.dispatched));
               check_field("retired", int'(want.retired), int'(got.retired));
            end
         end
         if (req_tvalid && req_tready) begin
            want = apply_request(req_tuser,
                                 req_tdata[IN_TIME_W-1:0],
                                 req_tdata[SLOT_LSB +: SLOT_W],
                                 req_tdata[PERIOD_LSB +: IN_TIME_W],
                                 req_tdata[COUNT_LSB +: COUNT_W]);
            dispatches  += want.dispatched;
            retirements += want.retired;
            full_hits   += (want.status == STAT_FULL);
            outcome_q.push_back(want);
         end
      end
      pending <= outcome_q.size();
   end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the periodic task timer table: clock, reset, request stimulus with
// random gaps, response back-pressure, watchdog and verdict.
// Depends on ptt_pkg, periodic_task_timer_table and timer_table_checker.

module tb;
   import ptt_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_RSVD = 3'd7;  // unused code, ignored by the block
   localparam int ITEM_TARGET  = 1750;
   localparam int CALM_FROM    = 1550;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 40;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [FUNC_W-1:0]     req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int          errors;
   int          pending;
   int          dispatches;
   int          retirements;
   int          full_hits;
   int          sent;
   int          gap_pct;
   int          stall_pct;
   int          idle_cycles;
   logic [31:0] t_us;

   periodic_task_timer_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   timer_table_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .errors      (errors),
      .pending     (pending),
      .dispatches  (dispatches),
      .retirements (retirements),
      .full_hits   (full_hits)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic push_req(input logic [FUNC_W-1:0] f, input logic [31:0] now,
                           input logic [SLOT_W-1:0] slot, input logic [31:0] per,
                           input logic [31:0] cnt);
      if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= {{(REQ_DATA_W - 3 * IN_TIME_W - SLOT_W){1'b0}}, cnt, per, slot, now};
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   // hold off requests until every response is back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   function automatic logic [31:0] pick_period();
      return ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 12);
   endfunction

   function automatic logic [31:0] pick_count();
      case ($urandom_range(0, 3))
         0:       return '0;
         3:       return $urandom;
         default: return $urandom_range(1, 4);
      endcase
   endfunction

   // optionally clear, add tasks, start the table and tick through an advancing time line, with other requests mixed in
   task automatic run_session();
      int n_add;
      int n_tick;
      int r;
      if ($urandom_range(0, 1))
         push_req(FUNC_CLEAR, $urandom, SLOT_W'($urandom), $urandom, $urandom);
      if ($urandom_range(0, 9) == 0)
         t_us = 32'hFFFF_FF00 + $urandom_range(0, 255);
      n_add = $urandom_range(1, 18);
      for (int k = 0; k < n_add; k++)
         push_req(FUNC_ADD, t_us, SLOT_W'($urandom), pick_period(), pick_count());
      push_req(FUNC_START, t_us, SLOT_W'($urandom), $urandom, $urandom);
      n_tick = $urandom_range(8, 40);
      for (int k = 0; k < n_tick; k++) begin
         t_us = t_us + $urandom_range(0, 8);
         r    = $urandom_range(0, 99);
         if (r < 80)
            push_req(FUNC_TICK, t_us, SLOT_W'($urandom), $urandom, $urandom);
         else if (r < 86)
            push_req(FUNC_ENABLE, t_us, SLOT_W'($urandom), $urandom, $urandom);
         else if (r < 92)
            push_req(FUNC_DISABLE, t_us, SLOT_W'($urandom), $urandom, $urandom);
         else if (r < 95)
            push_req(FUNC_ADD, t_us, SLOT_W'($urandom), pick_period(), pick_count());
         else if (r < 97)
            push_req(FUNC_STOP, t_us, SLOT_W'($urandom), $urandom, $urandom);
         else if (r < 99)
            push_req(FUNC_START, t_us, SLOT_W'($urandom), $urandom, $urandom);
         else
            push_req(FUNC_RSVD, t_us, SLOT_W'($urandom), $urandom, $urandom);
      end
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= FUNC_TICK;
      sent       = 0;
      gap_pct    = 0;
      stall_pct  = 0;
      t_us       = 32'd100;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // corner cases
      push_req(FUNC_TICK, '0, '0, '0, '0);
      push_req(FUNC_ENABLE, 32'h10, 4'd3, '0, '0);
      push_req(FUNC_DISABLE, '0, 4'd15, '0, '0);
      push_req(FUNC_ADD, '0, '0, '1, '0);
      push_req(FUNC_ADD, '1, '1, '0, 32'd1);
      push_req(FUNC_ADD, 32'h8000_0000, '0, 32'd1, '1);
      push_req(FUNC_RSVD, '1, '1, '1, '1);
      push_req(FUNC_TICK, '1, '0, '0, '0);
      push_req(FUNC_START, 32'h7FFF_FFFF, '0, '0, '0);
      push_req(FUNC_TICK, '0, '0, '0, '0);
      push_req(FUNC_TICK, 32'h7FFF_FFFF, '0, '0, '0);
      push_req(FUNC_ADD, 32'h7FFF_FFFF, '0, '0, 32'd2);
      push_req(FUNC_DISABLE, '0, 4'd0, '0, '0);
      push_req(FUNC_TICK, 32'h7FFF_FFFF, '0, '0, '0);
      push_req(FUNC_TICK, 32'h7FFF_FFFF, '0, '0, '0);
      push_req(FUNC_TICK, 32'h7FFF_FFFF, '0, '0, '0);
      push_req(FUNC_ENABLE, 32'h10, 4'd0, '0, '0);
      push_req(FUNC_STOP, '0, '0, '0, '0);
      push_req(FUNC_TICK, '1, '0, '0, '0);
      push_req(FUNC_START, 32'hFFFF_FFF0, '0, '0, '0);
      push_req(FUNC_TICK, '1, '0, '0, '0);
      push_req(FUNC_DISABLE, '0, 4'd0, '0, '0);
      push_req(FUNC_DISABLE, '0, 4'd2, '0, '0);
      push_req(FUNC_TICK, '1, '0, '0, '0);
      push_req(FUNC_TICK, '1, '0, '0, '0);
      push_req(FUNC_CLEAR, '0, '0, '0, '0);
      drain();

      while (sent < ITEM_TARGET) begin
         if (sent >= CALM_FROM) begin
            gap_pct   = 0;
            stall_pct = 0;
         end else begin
            gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : 30;
            stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
         end
         case ($urandom_range(0, 9))
            0: begin
               repeat ($urandom_range(1, 4))
                  push_req(FUNC_W'($urandom_range(0, 7)), $urandom, SLOT_W'($urandom),
                           $urandom, $urandom);
            end
            1: begin
               if (sent < CALM_FROM)
                  drain();
            end
            default: run_session();
         endcase
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Run covered %0d requests: %0d dispatches, %0d retirements, %0d full-table adds",
               sent, dispatches, retirements, full_hits);
      $display("Directed corners, random add/start/tick sessions with time wrap, noise, stalls");
      if (errors == 0 && pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // response back-pressure in short random bursts
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // watchdog: no request or response moving for too long
   initial idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: watchdog expired, no handshake for %0d cycles", $time, STALL_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/ptt_pkg.sv
rtl/ptt_ram.sv
rtl/ptt_dpath.sv
rtl/ptt_ctrl.sv
rtl/periodic_task_timer_table.sv
tb/timer_table_checker.sv
tb/tb.sv
